// ===== hw/rtl/pita_pkg.sv =====
// Shared types, constants and the square-root step for the angle-sum triangle test.
`default_nettype none
package pita_pkg;

  typedef logic signed [31:0] coord_t;

  localparam logic [18:0] TOL_RESET  = 19'd6554;
  localparam logic [20:0] TWO_PI     = 21'd411775;
  localparam logic [17:0] PI_VAL     = 18'd205887;
  localparam logic [16:0] HALF_PI    = 17'd102944;
  localparam logic [16:0] ONE_VAL    = 17'd65536;
  localparam int          ATAN_DEPTH = 24;

  // round(atan(2^-i) * 2^16)
  localparam logic [15:0] ATAN_TABLE [ATAN_DEPTH] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,
    16'd1,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
  };

  // digit-by-digit square root, one result bit per step
  typedef struct packed {
    logic [19:0] rem;
    logic [16:0] root;
  } sqrt_acc_t;

  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [19:0] t;
    logic [19:0] trial;
    sqrt_acc_t   r;
    t     = {acc.rem[17:0], pair};
    trial = {1'b0, acc.root, 2'b01};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {acc.root[15:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {acc.root[15:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pita_if.sv =====
// Channel interfaces: query word, result word and tolerance write.
`default_nettype none
interface pita_in_if;
  import pita_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x, point_y, point_z;
  coord_t first_x, first_y, first_z;
  coord_t second_x, second_y, second_z;
  coord_t third_x, third_y, third_z;
  modport source (output valid, point_x, point_y, point_z, first_x, first_y, first_z,
                  second_x, second_y, second_z, third_x, third_y, third_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, first_x, first_y, first_z,
                  second_x, second_y, second_z, third_x, third_y, third_z, output ready);
endinterface

interface pita_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [19:0] angle_sum;
  modport source (output valid, inside_res, angle_sum, input ready);
  modport sink   (input valid, inside_res, angle_sum, output ready);
endinterface

interface pita_cfg_if;
  logic        valid;
  logic        ready;
  logic [18:0] angle_tolerance;
  modport source (output valid, angle_tolerance, input ready);
  modport sink   (input valid, angle_tolerance, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/point_in_triangle_angle_sum.sv =====
// Angle-sum point-in-triangle test, fully pipelined.
// Stages: differences, block scaling, squares and the length sqrt, the per-component
//   divider, unit vectors, products, dots, the sine sqrt, the CORDIC chain and the
//   result register, one step group per stage.
// Throughput: one word per cycle unless the result stalls; every stage is a register
//   slice. A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) clears the valid bits and sets angle_tolerance to 6554.
`default_nettype none
module point_in_triangle_angle_sum #(
  parameter int ACOS_ITERATIONS = 16
) (
  input  wire         clk,
  input  wire         rst,
  pita_cfg_if.sink    cfg,
  pita_in_if.sink     item,
  pita_out_if.source  result
);
  import pita_pkg::*;

  localparam int SQ1_STEPS = 16;               // 32-bit radicand
  localparam int SQ1_ST    = SQ1_STEPS / 2;
  localparam int QBITS     = 17;               // quotient bits of unit component
  localparam int DIV_ST    = (QBITS + 1) / 2;
  localparam int SQ2_STEPS = 17;               // 33-bit radicand padded to 34
  localparam int SQ2_ST    = (SQ2_STEPS + 1) / 2;
  localparam int NIT       = ACOS_ITERATIONS;
  localparam int LAT       = 36 + NIT;

  // ---------------------------------------------------------------- control
  logic [18:0]    tol;
  logic [LAT-1:0] vld;
  logic           adv;   // whole pipe moves when the output slot is free or drained

  assign adv          = !vld[LAT-1] || result.ready;
  assign item.ready   = adv;
  assign cfg.ready    = 1'b1;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
      vld <= '0;
    end else begin
      if (cfg.valid) tol <= cfg.angle_tolerance;
      if (adv) vld <= {vld[LAT-2:0], item.valid};
    end
  end

  // ---------------------------------------------------------------- stage 1: differences
  coord_t pt [3];
  coord_t vx [3][3];
  assign pt[0] = item.point_x;  assign pt[1] = item.point_y;  assign pt[2] = item.point_z;
  assign vx[0][0] = item.first_x;  assign vx[0][1] = item.first_y;  assign vx[0][2] = item.first_z;
  assign vx[1][0] = item.second_x; assign vx[1][1] = item.second_y; assign vx[1][2] = item.second_z;
  assign vx[2][0] = item.third_x;  assign vx[2][1] = item.third_y;  assign vx[2][2] = item.third_z;

  logic [32:0] s1_mag [3][3];
  logic        s1_neg [3][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [32:0] d;
          d = {pt[j][31], pt[j]} - {vx[k][j][31], vx[k][j]};
          s1_neg[k][j] <= d[32];
          s1_mag[k][j] <= d[32] ? 33'(-d) : 33'(d);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: block scaling
  // leading one of the OR equals that of the largest magnitude
  logic [5:0]  msb  [3];
  logic        zero [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [32:0] orv;
      orv    = s1_mag[k][0] | s1_mag[k][1] | s1_mag[k][2];
      msb[k] = '0;
      for (int b = 0; b < 33; b++) begin
        if (orv[b]) msb[k] = 6'(b);
      end
      zero[k] = (orv == '0);
    end
  end

  logic [14:0] s2_sm   [3][3];
  logic        s2_neg  [3][3];
  logic        s2_zero [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_zero[k] <= zero[k];
        for (int j = 0; j < 3; j++) begin
          s2_neg[k][j] <= s1_neg[k][j];
          if (msb[k] >= 6'd14) s2_sm[k][j] <= 15'(s1_mag[k][j] >> (msb[k] - 6'd14));
          else                 s2_sm[k][j] <= 15'(s1_mag[k][j] << (6'd14 - msb[k]));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3 + length sqrt
  sqrt_acc_t   q1_acc  [0:SQ1_ST][3];
  logic [31:0] q1_val  [0:SQ1_ST][3];
  logic [14:0] q1_sm   [0:SQ1_ST][3][3];
  logic        q1_neg  [0:SQ1_ST][3][3];
  logic        q1_zero [0:SQ1_ST][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [29:0] p0, p1, p2;
        p0 = 30'(s2_sm[k][0]) * 30'(s2_sm[k][0]);
        p1 = 30'(s2_sm[k][1]) * 30'(s2_sm[k][1]);
        p2 = 30'(s2_sm[k][2]) * 30'(s2_sm[k][2]);
        q1_val[0][k]  <= 32'(p0) + 32'(p1) + 32'(p2);
        q1_acc[0][k]  <= '0;
        q1_zero[0][k] <= s2_zero[k];
        for (int j = 0; j < 3; j++) begin
          q1_sm[0][k][j]  <= s2_sm[k][j];
          q1_neg[0][k][j] <= s2_neg[k][j];
        end
      end
    end
  end

  for (genvar s = 1; s <= SQ1_ST; s++) begin : g_sq1
    for (genvar k = 0; k < 3; k++) begin : g_v
      sqrt_acc_t mid, fin;
      assign mid = sqrt_step(q1_acc[s-1][k], q1_val[s-1][k][31:30]);
      assign fin = sqrt_step(mid, q1_val[s-1][k][29:28]);
      always_ff @(posedge clk) begin
        if (adv) begin
          q1_acc[s][k]  <= fin;
          q1_val[s][k]  <= {q1_val[s-1][k][27:0], 4'b0};
          q1_zero[s][k] <= q1_zero[s-1][k];
          q1_sm[s][k]   <= q1_sm[s-1][k];
          q1_neg[s][k]  <= q1_neg[s-1][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- divider: round(mag*2^16/len)
  logic [32:0] dv_rem  [0:DIV_ST][3][3];
  logic [16:0] dv_q    [0:DIV_ST][3][3];
  logic [15:0] dv_len  [0:DIV_ST][3];
  logic        dv_neg  [0:DIV_ST][3][3];
  logic        dv_zero [0:DIV_ST][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [15:0] len;
        len = q1_acc[SQ1_ST][k].root[15:0];
        dv_len[0][k]  <= len;
        dv_zero[0][k] <= q1_zero[SQ1_ST][k];
        for (int j = 0; j < 3; j++) begin
          dv_rem[0][k][j] <= {2'b0, q1_sm[SQ1_ST][k][j], 16'b0} + 33'(len >> 1);
          dv_q[0][k][j]   <= '0;
          dv_neg[0][k][j] <= q1_neg[SQ1_ST][k][j];
        end
      end
    end
  end

  for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
    localparam int B0  = QBITS - 1 - 2 * (s - 1);
    localparam bit TWO = (B0 >= 1);
    localparam int B1  = TWO ? B0 - 1 : 0;
    for (genvar k = 0; k < 3; k++) begin : g_v
      logic [32:0] d0, d1;
      assign d0 = 33'(dv_len[s-1][k]) << B0;
      assign d1 = 33'(dv_len[s-1][k]) << B1;
      for (genvar j = 0; j < 3; j++) begin : g_c
        logic [32:0] r0, r1;
        logic [16:0] q0, q1;
        always_comb begin
          r0 = dv_rem[s-1][k][j];
          q0 = dv_q[s-1][k][j];
          if (r0 >= d0) begin
            r0 = r0 - d0;
            q0 = q0 | (17'd1 << B0);
          end
          r1 = r0;
          q1 = q0;
          if (TWO && (r1 >= d1)) begin
            r1 = r1 - d1;
            q1 = q1 | (17'd1 << B1);
          end
        end
        always_ff @(posedge clk) begin
          if (adv) begin
            dv_rem[s][k][j] <= r1;
            dv_q[s][k][j]   <= q1;
            dv_neg[s][k][j] <= dv_neg[s-1][k][j];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_len[s][k]  <= dv_len[s-1][k];
          dv_zero[s][k] <= dv_zero[s-1][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- unit vectors, dots
  logic signed [17:0] un [3][3];
  logic signed [35:0] pr [3][3];
  logic signed [17:0] cs [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [17:0] qs;
          qs = $signed({1'b0, dv_q[DIV_ST][k][j]});
          if (dv_zero[DIV_ST][k])        un[k][j] <= '0;
          else if (dv_neg[DIV_ST][k][j]) un[k][j] <= -qs;
          else                           un[k][j] <= qs;
        end
      end
    end
  end

  // pairs: (0,1), (1,2), (2,0)
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          pr[a][j] <= un[a][j] * un[(a + 1) % 3][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [35:0] sm;
        logic [35:0]        smag;
        logic [19:0]        r;
        logic [16:0]        rc;
        sm   = pr[a][0] + pr[a][1] + pr[a][2];
        smag = sm[35] ? 36'(-sm) : 36'(sm);
        r    = 20'((smag + 36'd32768) >> 16);
        rc   = (r > 20'(ONE_VAL)) ? ONE_VAL : r[16:0];
        cs[a] <= sm[35] ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
      end
    end
  end

  // ---------------------------------------------------------------- sine via sqrt(1 - cos^2)
  sqrt_acc_t          q2_acc [0:SQ2_ST][3];
  logic [33:0]        q2_val [0:SQ2_ST][3];
  logic signed [17:0] q2_c   [0:SQ2_ST][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [35:0] c2;
        c2 = cs[a] * cs[a];
        q2_val[0][a] <= {1'b0, 33'h1_0000_0000 - c2[32:0]};
        q2_acc[0][a] <= '0;
        q2_c[0][a]   <= cs[a];
      end
    end
  end

  for (genvar s = 1; s <= SQ2_ST; s++) begin : g_sq2
    localparam bit TWO = (2 * (s - 1) + 1 < SQ2_STEPS);
    for (genvar a = 0; a < 3; a++) begin : g_v
      sqrt_acc_t mid, fin;
      assign mid = sqrt_step(q2_acc[s-1][a], q2_val[s-1][a][33:32]);
      assign fin = TWO ? sqrt_step(mid, q2_val[s-1][a][31:30]) : mid;
      always_ff @(posedge clk) begin
        if (adv) begin
          q2_acc[s][a] <= fin;
          q2_val[s][a] <= {q2_val[s-1][a][29:0], 4'b0};
          q2_c[s][a]   <= q2_c[s-1][a];
        end
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC arc cosine
  logic signed [19:0] cr_x [0:NIT][3];
  logic signed [19:0] cr_y [0:NIT][3];
  logic signed [19:0] cr_a [0:NIT][3];

  // negative cos: rotate the start vector by -pi/2, angle starts at pi/2
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [19:0] cx, sy;
        cx = 20'(q2_c[SQ2_ST][a]);
        sy = $signed({3'b0, q2_acc[SQ2_ST][a].root});
        if (cx < 0) begin
          cr_x[0][a] <= sy;
          cr_y[0][a] <= -cx;
          cr_a[0][a] <= $signed({3'b0, HALF_PI});
        end else begin
          cr_x[0][a] <= cx;
          cr_y[0][a] <= sy;
          cr_a[0][a] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    localparam logic signed [19:0] TA = $signed({4'b0, ATAN_TABLE[i]});
    for (genvar a = 0; a < 3; a++) begin : g_v
      logic signed [19:0] xs, ys;
      assign xs = cr_x[i][a] >>> i;
      assign ys = cr_y[i][a] >>> i;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (cr_y[i][a] > 0) begin
            cr_x[i+1][a] <= cr_x[i][a] + ys;
            cr_y[i+1][a] <= cr_y[i][a] - xs;
            cr_a[i+1][a] <= cr_a[i][a] + TA;
          end else begin
            cr_x[i+1][a] <= cr_x[i][a] - ys;
            cr_y[i+1][a] <= cr_y[i][a] + xs;
            cr_a[i+1][a] <= cr_a[i][a] - TA;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- clamp, sum, decide
  logic [19:0] sum_next;
  logic        inside_next;
  always_comb begin
    logic [17:0]        ac [3];
    logic signed [20:0] dev;
    for (int a = 0; a < 3; a++) begin
      if (cr_a[NIT][a] < 0)                            ac[a] = '0;
      else if (cr_a[NIT][a] > $signed({2'b0, PI_VAL})) ac[a] = PI_VAL;
      else                                             ac[a] = cr_a[NIT][a][17:0];
    end
    sum_next    = 20'(ac[0]) + 20'(ac[1]) + 20'(ac[2]);
    dev         = $signed({1'b0, sum_next}) - $signed(TWO_PI);
    if (dev < 0) dev = -dev;
    inside_next = (dev < $signed({2'b0, tol}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.angle_sum  <= sum_next;
      result.inside_res <= inside_next;
    end
  end

`ifndef SYNTH
  // a held result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !item.ready)
    else $error("input taken while result stalled");

  // valid bits freeze during a stall
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");

  // three clamped angles never exceed three pi
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.angle_sum <= 20'd617661))
    else $error("angle sum out of range");

  // accepted word shows up in the first valid bit
  a_accept_tracked: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> vld[0])
    else $error("accepted word lost");
`endif

endmodule
`default_nettype wire
